FILE: rtl/tdma_peer_slot_scheduler_core_assert.svh
// Assertion macros for the TDMA peer slot scheduler.
`ifndef TDMA_PEER_SLOT_SCHEDULER_CORE_ASSERT_SVH
`define TDMA_PEER_SLOT_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TPS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPS_ASSERT(label, clk, rst, prop, msg)
`define TPS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/tps_pkg.sv
// Shared types and constants of the TDMA peer slot scheduler.
package tps_pkg;
  localparam int MaxPeers = 16;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam int TimeW = 32;
  localparam int SumW = 48;

  localparam logic [2:0] REG_OWN_ID = 3'd0;
  localparam logic [2:0] REG_DEAD = 3'd1;
  localparam logic [2:0] REG_INIT_PERIOD = 3'd2;
  localparam logic [2:0] REG_RATIO = 3'd3;
  localparam logic [2:0] REG_PMIN = 3'd4;
  localparam logic [2:0] REG_PMAX = 3'd5;

  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_SEND = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_DECIDE, ST_COMPACT, ST_SORT, ST_OWN, ST_POS,
    ST_ADAPT, ST_MUL1, ST_MUL2, ST_MUL3, ST_CMP, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] id;
    logic [TimeW-1:0] seen;
    logic [TimeW-1:0] prev;
  } entry_t;
endpackage

FILE: rtl/tdma_peer_slot_scheduler_core.sv
// Flow: every request runs the id scan over all table entries and the decide step; a send
// check that is not due, a dropped packet or an own id already present then ends.
// Table upkeep adds compaction, insertion sort (shifts and placements) and an own slot scan
// over all table entries; adaptation adds sum, 3 multiply steps, clamp and a 16-step
// division. done strobes in the same cycle in which busy falls, a new request is taken in
// that cycle, and the receiver cannot stall. Reset: synchronous, active high.
`include "tdma_peer_slot_scheduler_core_assert.svh"
module tdma_peer_slot_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  peer_id,
  input  logic [31:0] now,
  output logic        done,
  output logic        send_now,
  output logic [31:0] next_send_time,
  output logic [15:0] period_now,
  output logic [3:0]  slot_index,
  output logic [4:0]  peer_total,
  output logic        partner_online,
  output logic        drop_flag
);
  localparam int N = tps_pkg::MaxPeers;
  localparam int IW = tps_pkg::IdxW;
  localparam int CW = tps_pkg::CntW;
  localparam int TW = tps_pkg::TimeW;
  localparam int SW = tps_pkg::SumW;

  logic [7:0]  own_id;
  logic [15:0] dead_threshold, initial_period, ratio_threshold, period_min, period_max;

  tps_pkg::entry_t tbl [N];
  logic [CW-1:0] entry_count;
  logic [IW-1:0] own_slot;
  logic          partner_flag;
  logic [15:0]   cur_period;
  logic [TW-1:0] tx_due_time;
  logic [7:0]    last_sender;
  logic [SW-1:0] period_sum;
  logic [31:0]   period_samples;

  tps_pkg::state_t state, state_next;
  logic          rtype;
  logic [7:0]    rid;
  logic [7:0]    mid;
  logic [TW-1:0] rnow;
  logic [CW-1:0] i, j, k;
  logic          found;
  logic [IW-1:0] fpos;
  logic          fdrop, fsend;
  logic [31:0]   prod;
  logic [SW+8-1:0] lhs;
  logic [63:0]   rhs;
  logic [15:0]   quo, rem_q;
  logic [4:0]    dstep;
  tps_pkg::entry_t key;
  // known-sender flag held from decide; sender presence tracked during own scan
  logic found_known, mid_alive;

  logic wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign busy = (state != tps_pkg::ST_IDLE);

  always_comb begin
    case (paddr[4:2])
      tps_pkg::REG_OWN_ID:      prdata = {24'd0, own_id};
      tps_pkg::REG_DEAD:        prdata = {16'd0, dead_threshold};
      tps_pkg::REG_INIT_PERIOD: prdata = {16'd0, initial_period};
      tps_pkg::REG_RATIO:       prdata = {16'd0, ratio_threshold};
      tps_pkg::REG_PMIN:        prdata = {16'd0, period_min};
      tps_pkg::REG_PMAX:        prdata = {16'd0, period_max};
      default:                  prdata = 32'd0;
    endcase
  end

  // Shared compare unit operands
  tps_pkg::entry_t ei;
  logic [TW-1:0] age;
  logic          alive;
  assign ei = tbl[i[IW-1:0]];
  assign age = rnow - ei.seen;
  assign alive = (age <= {{(TW-16){1'b0}}, dead_threshold});

  logic [31:0] d;
  logic [SW-1:0] dext, sum_sat;
  logic [SW:0]   sum_add;
  assign d = ei.seen - ei.prev;
  assign dext = {{(SW-32){1'b0}}, d};
  assign sum_add = {1'b0, period_sum} + {1'b0, dext};
  assign sum_sat = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];

  logic signed [17:0] pstep;
  logic [16:0] rtrial;
  logic        qbit;
  assign pstep = ({8'd0, lhs} < rhs) ? $signed({2'b00, cur_period}) - 18'sd3
                                     : $signed({2'b00, cur_period}) + 18'sd1;
  assign rtrial = {rem_q, cur_period[4'd15 - dstep[3:0]]};
  assign qbit = (rtrial >= {12'd0, entry_count});

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd1; dead_threshold <= 16'd1000; initial_period <= 16'd100;
      ratio_threshold <= 16'd256; period_min <= 16'd20; period_max <= 16'd1000;
      for (int n = 1; n < N; n++) tbl[n] <= '0;
      tbl[0] <= '{id: 8'd1, seen: '0, prev: '0};
      entry_count <= CW'(1); own_slot <= '0; partner_flag <= 1'b0;
      cur_period <= 16'd100; tx_due_time <= '0; last_sender <= '0;
      period_sum <= '0; period_samples <= '0;
      send_now <= 1'b0; drop_flag <= 1'b0;
      done <= 1'b0;
      state <= tps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
      done <= (state == tps_pkg::ST_DONE);
      if (wr) begin
        case (paddr[4:2])
          tps_pkg::REG_OWN_ID: begin
            own_id <= pwdata[7:0];
            for (int n = 1; n < N; n++) tbl[n] <= '0;
            tbl[0] <= '{id: pwdata[7:0], seen: '0, prev: '0};
            entry_count <= CW'(1); own_slot <= '0; partner_flag <= 1'b0;
          end
          tps_pkg::REG_DEAD: dead_threshold <= pwdata[15:0];
          tps_pkg::REG_INIT_PERIOD: begin
            initial_period <= pwdata[15:0]; cur_period <= pwdata[15:0];
          end
          tps_pkg::REG_RATIO: ratio_threshold <= pwdata[15:0];
          tps_pkg::REG_PMIN: period_min <= pwdata[15:0];
          tps_pkg::REG_PMAX: period_max <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state)
        tps_pkg::ST_IDLE: begin
          if (start) begin
            rtype <= req_type; rid <= peer_id; rnow <= now;
            i <= '0; found <= 1'b0; fdrop <= 1'b0; fsend <= 1'b0;
            mid <= (req_type == tps_pkg::REQ_SEND) ? own_id : peer_id;
          end
        end
        tps_pkg::ST_FIND: begin
          // scan one entry a cycle for the sender
          if (i < entry_count && ei.id == mid && !found) begin
            found <= 1'b1; fpos <= i[IW-1:0];
          end
          i <= i + CW'(1);
        end
        tps_pkg::ST_DECIDE: begin
          i <= '0; j <= '0;
          if (rtype == tps_pkg::REQ_SEND) begin
            if (rnow >= tx_due_time) begin
              fsend <= 1'b1;
              tx_due_time <= tx_due_time + {{(TW-16){1'b0}}, cur_period};
              if (found) tbl[fpos] <= '{id: tbl[fpos].id, seen: rnow, prev: tbl[fpos].seen};
            end
          end else if (!found) begin
            if (entry_count >= CW'(N)) fdrop <= 1'b1;
            else begin
              tbl[entry_count[IW-1:0]] <= '{id: rid, seen: rnow, prev: rnow};
              entry_count <= entry_count + CW'(1);
            end
          end else if (rid != own_id) begin
            tbl[fpos] <= '{id: tbl[fpos].id, seen: rnow, prev: tbl[fpos].seen};
          end
        end
        tps_pkg::ST_COMPACT: begin
          // drop silent entries, keep order
          if (i < entry_count) begin
            if (alive) begin
              tbl[j[IW-1:0]] <= ei;
              j <= j + CW'(1);
            end
            i <= i + CW'(1);
          end else begin
            entry_count <= j;
            i <= CW'(1);
            k <= CW'(1);
            key <= tbl[1];
          end
        end
        tps_pkg::ST_SORT: begin
          // insertion sort: one shift or placement per cycle
          if (i < entry_count) begin
            if (k != '0 && tbl[k[IW-1:0] - IW'(1)].id > key.id) begin
              tbl[k[IW-1:0]] <= tbl[k[IW-1:0] - IW'(1)];
              k <= k - CW'(1);
            end else begin
              tbl[k[IW-1:0]] <= key;
              i <= i + CW'(1);
              k <= i + CW'(1);
              key <= tbl[i[IW-1:0] + IW'(1)];
            end
          end else begin
            i <= '0; found <= 1'b0;
          end
        end
        tps_pkg::ST_OWN: begin
          if (i < entry_count && ei.id == own_id && !found) begin
            found <= 1'b1; own_slot <= i[IW-1:0];
          end
          if (i < entry_count && ei.id == mid) fpos <= i[IW-1:0];
          i <= i + CW'(1);
          partner_flag <= (entry_count > CW'(1));
        end
        tps_pkg::ST_POS: begin
          i <= {1'b0, fpos};
        end
        tps_pkg::ST_ADAPT: begin
          if (period_samples == '0 || last_sender == rid) begin
            period_sum <= sum_sat;
            if (period_samples != 32'hFFFF_FFFF) period_samples <= period_samples + 32'd1;
          end else begin
            period_sum <= dext;
            period_samples <= 32'd1;
          end
        end
        tps_pkg::ST_MUL1: prod <= {16'd0, ratio_threshold} * {16'd0, cur_period};
        tps_pkg::ST_MUL2: rhs <= {32'd0, prod} * {32'd0, period_samples};
        tps_pkg::ST_MUL3: lhs <= {period_sum, 8'd0};
        tps_pkg::ST_CMP: begin
          if (pstep < $signed({2'b00, period_min})) cur_period <= period_min;
          else if (pstep > $signed({2'b00, period_max})) cur_period <= period_max;
          else cur_period <= pstep[15:0];
          dstep <= '0; rem_q <= '0; quo <= '0;
          last_sender <= rid;
        end
        tps_pkg::ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (qbit) begin
            rem_q <= 16'(rtrial - {12'd0, entry_count});
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem_q <= rtrial[15:0];
            quo <= {quo[14:0], 1'b0};
          end
          dstep <= dstep + 5'd1;
          if (dstep == 5'd15)
            tx_due_time <= ei.seen + {16'd0, quo[14:0], qbit};
        end
        tps_pkg::ST_DONE: begin
          send_now <= fsend; drop_flag <= fdrop;
        end
        default: ;
      endcase
    end
  end

  logic [7:0] hop;
  logic [7:0] rr;
  assign rr = {4'd0, fpos};
  assign hop = (own_slot > fpos) ? 8'(rr + {3'd0, entry_count} - {4'd0, own_slot})
                                 : 8'(rr - {4'd0, own_slot});

  always_comb begin
    state_next = state;
    case (state)
      tps_pkg::ST_IDLE: if (start) state_next = tps_pkg::ST_FIND;
      tps_pkg::ST_FIND: if (i == CW'(N - 1)) state_next = tps_pkg::ST_DECIDE;
      tps_pkg::ST_DECIDE: begin
        if (rtype == tps_pkg::REQ_SEND)
          state_next = (rnow >= tx_due_time) ? tps_pkg::ST_COMPACT : tps_pkg::ST_DONE;
        else if (!found)
          state_next = (entry_count >= CW'(N)) ? tps_pkg::ST_DONE : tps_pkg::ST_COMPACT;
        else
          state_next = (rid == own_id) ? tps_pkg::ST_DONE : tps_pkg::ST_COMPACT;
      end
      tps_pkg::ST_COMPACT: if (!(i < entry_count)) state_next = tps_pkg::ST_SORT;
      tps_pkg::ST_SORT: if (!(i < entry_count)) state_next = tps_pkg::ST_OWN;
      tps_pkg::ST_OWN: if (i == CW'(N - 1)) state_next = tps_pkg::ST_POS;
      tps_pkg::ST_POS: begin
        // only a refreshed known sender may adapt
        if (rtype == tps_pkg::REQ_PACKET && found_known && mid_alive && entry_count != '0
            && hop == 8'(entry_count - CW'(1)))
          state_next = tps_pkg::ST_ADAPT;
        else
          state_next = tps_pkg::ST_DONE;
      end
      tps_pkg::ST_ADAPT: state_next = tps_pkg::ST_MUL1;
      tps_pkg::ST_MUL1: state_next = tps_pkg::ST_MUL2;
      tps_pkg::ST_MUL2: state_next = tps_pkg::ST_MUL3;
      tps_pkg::ST_MUL3: state_next = tps_pkg::ST_CMP;
      tps_pkg::ST_CMP: state_next = tps_pkg::ST_DIV;
      tps_pkg::ST_DIV: if (dstep == 5'd15) state_next = tps_pkg::ST_DONE;
      tps_pkg::ST_DONE: state_next = tps_pkg::ST_IDLE;
      default: state_next = tps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_known <= 1'b0; mid_alive <= 1'b0;
    end else begin
      if (state == tps_pkg::ST_DECIDE) found_known <= found;
      if (state == tps_pkg::ST_SORT) mid_alive <= 1'b0;
      if (state == tps_pkg::ST_OWN && i < entry_count && ei.id == mid) mid_alive <= 1'b1;
    end
  end

  assign next_send_time = tx_due_time;
  assign period_now = cur_period;
  assign slot_index = own_slot;
  assign peer_total = entry_count;
  assign partner_online = partner_flag;

  `TPS_ASSERT(a_done_pulse, clk, rst, done |=> !done, "done longer than one cycle")
  `TPS_ASSERT(a_count_max, clk, rst, entry_count <= CW'(N), "peer count above table size")
  `TPS_ASSERT(a_start_busy, clk, rst, (start && !busy) |=> busy, "request not taken")
  `TPS_ASSERT(a_drop_only_packet, clk, rst, (done && drop_flag) |-> !send_now, "drop on send")
endmodule

FILE: test/tdma_peer_slot_scheduler_core_test.sv
// Self-checking testbench for the TDMA peer slot scheduler core.
`timescale 1ns / 1ps
module tdma_peer_slot_scheduler_core_test;

  typedef struct packed {
    logic        send_now;
    logic [31:0] next_send_time;
    logic [15:0] period_now;
    logic [3:0]  slot_index;
    logic [4:0]  peer_total;
    logic        partner_online;
    logic        drop_flag;
  } sched_result_t;

  localparam logic [63:0] SumLimit = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] SampleLimit = 64'hFFFF_FFFF;
  localparam int ExpDepth = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = tps_pkg::REQ_PACKET;
  logic [7:0]  peer_id = '0;
  logic [31:0] now = '0;
  logic        done;
  logic        send_now;
  logic [31:0] next_send_time;
  logic [15:0] period_now;
  logic [3:0]  slot_index;
  logic [4:0]  peer_total;
  logic        partner_online;
  logic        drop_flag;

  tdma_peer_slot_scheduler_core i_dut (.*);

  always #4 clk = ~clk;

  // Shadow copy of the scheduler state and registers
  logic [7:0]  cfg_own_id;
  logic [15:0] cfg_dead, cfg_init_period, cfg_ratio, cfg_pmin, cfg_pmax;
  logic [7:0]  tbl_id [tps_pkg::MaxPeers];
  logic [31:0] tbl_seen [tps_pkg::MaxPeers];
  logic [31:0] tbl_prev [tps_pkg::MaxPeers];
  int          tbl_count;
  int          own_slot;
  logic        partner;
  logic [15:0] cur_period;
  logic [31:0] due_time;
  logic [7:0]  last_sender;
  logic [63:0] period_sum;
  logic [63:0] period_samples;

  sched_result_t expected_results [ExpDepth];
  int          exp_head = 0;
  int          exp_count = 0;
  int          error_count = 0;
  logic [31:0] clock_ms = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic queue_result(input sched_result_t res);
    expected_results[(exp_head + exp_count) % ExpDepth] = res;
    exp_count++;
  endtask

  function automatic void table_clear();
    for (int i = 0; i < tps_pkg::MaxPeers; i++) begin
      tbl_id[i] = '0;
      tbl_seen[i] = '0;
      tbl_prev[i] = '0;
    end
    tbl_id[0] = cfg_own_id;
    tbl_count = 1;
    own_slot = 0;
    partner = 1'b0;
  endfunction

  function automatic int find_peer(input logic [7:0] id);
    for (int i = 0; i < tbl_count && i < tps_pkg::MaxPeers; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  // Refresh the entry, drop silent peers, sort by id, relocate own slot.
  function automatic void upkeep(input logic [7:0] id, input logic [31:0] t);
    int pos, j, k;
    logic [31:0] age;
    logic [7:0] kid;
    logic [31:0] ks, kp;
    pos = find_peer(id);
    if (pos >= 0) begin
      tbl_prev[pos] = tbl_seen[pos];
      tbl_seen[pos] = t;
    end
    j = 0;
    for (int i = 0; i < tbl_count && i < tps_pkg::MaxPeers; i++) begin
      age = t - tbl_seen[i];
      if (age <= {16'd0, cfg_dead}) begin
        tbl_id[j] = tbl_id[i];
        tbl_seen[j] = tbl_seen[i];
        tbl_prev[j] = tbl_prev[i];
        j++;
      end
    end
    tbl_count = j;
    for (int i = 1; i < tbl_count; i++) begin
      kid = tbl_id[i];
      ks = tbl_seen[i];
      kp = tbl_prev[i];
      k = i;
      while (k > 0 && tbl_id[k-1] > kid) begin
        tbl_id[k] = tbl_id[k-1];
        tbl_seen[k] = tbl_seen[k-1];
        tbl_prev[k] = tbl_prev[k-1];
        k--;
      end
      tbl_id[k] = kid;
      tbl_seen[k] = ks;
      tbl_prev[k] = kp;
    end
    pos = find_peer(cfg_own_id);
    if (pos >= 0) own_slot = pos;
    partner = tbl_count > 1;
  endfunction

  function automatic void adapt_period(input int r, input logic [7:0] sender);
    logic [31:0] d;
    logic [63:0] lhs, rhs;
    int p;
    d = tbl_seen[r] - tbl_prev[r];
    if (period_samples == 0 || last_sender == sender) begin
      period_sum = ({32'd0, d} > SumLimit - period_sum) ? SumLimit : period_sum + d;
      if (period_samples < SampleLimit) period_samples++;
    end else begin
      period_sum = {32'd0, d};
      period_samples = 1;
    end
    lhs = period_sum << 8;
    rhs = {48'd0, cfg_ratio} * {48'd0, cur_period} * period_samples;
    p = int'(cur_period);
    if (lhs < rhs) p -= 3;
    else p += 1;
    if (p < int'(cfg_pmin)) p = int'(cfg_pmin);
    else if (p > int'(cfg_pmax)) p = int'(cfg_pmax);
    cur_period = p[15:0];
    due_time = tbl_seen[r] + 32'(int'(cur_period) / tbl_count);
    last_sender = sender;
  endfunction

  function automatic logic packet_event(input logic [7:0] id, input logic [31:0] t);
    int pos, r, hop;
    pos = find_peer(id);
    if (pos < 0) begin
      if (tbl_count >= tps_pkg::MaxPeers) return 1'b1;
      tbl_id[tbl_count] = id;
      tbl_seen[tbl_count] = t;
      tbl_prev[tbl_count] = t;
      tbl_count++;
      upkeep(id, t);
      return 1'b0;
    end
    if (id == cfg_own_id) return 1'b0;
    upkeep(id, t);
    pos = find_peer(id);
    if (pos < 0 || tbl_count == 0) return 1'b0;
    r = pos;
    if (own_slot > r) hop = (r + tbl_count - own_slot) & 255;
    else hop = (r - own_slot) & 255;
    if (hop == tbl_count - 1) adapt_period(r, id);
    return 1'b0;
  endfunction

  function automatic sched_result_t schedule_step(input logic kind, input logic [7:0] id,
                                                  input logic [31:0] t);
    sched_result_t res;
    res = '0;
    if (kind == tps_pkg::REQ_PACKET) begin
      res.drop_flag = packet_event(id, t);
    end else if (t >= due_time) begin
      upkeep(cfg_own_id, t);
      due_time = due_time + {16'd0, cur_period};
      res.send_now = 1'b1;
    end
    res.next_send_time = due_time;
    res.period_now = cur_period;
    res.slot_index = own_slot[3:0];
    res.peer_total = tbl_count[4:0];
    res.partner_online = partner;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one request; start stays high so a zero gap gives back-to-back requests.
  task automatic send_request(input logic kind, input logic [7:0] id, input logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= kind;
    peer_id <= id;
    now <= t;
    do @(posedge clk); while (busy);
    queue_result(schedule_step(kind, id, t));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (exp_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tps_pkg::REG_OWN_ID: begin
        cfg_own_id = value[7:0];
        table_clear();
      end
      tps_pkg::REG_DEAD: cfg_dead = value[15:0];
      tps_pkg::REG_INIT_PERIOD: begin
        cfg_init_period = value[15:0];
        cur_period = value[15:0];
      end
      tps_pkg::REG_RATIO: cfg_ratio = value[15:0];
      tps_pkg::REG_PMIN: cfg_pmin = value[15:0];
      tps_pkg::REG_PMAX: cfg_pmax = value[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] own, input logic [15:0] dead,
                           input logic [15:0] init_p, input logic [15:0] ratio,
                           input logic [15:0] pmin, input logic [15:0] pmax);
    write_reg(tps_pkg::REG_DEAD, {16'd0, dead});
    write_reg(tps_pkg::REG_RATIO, {16'd0, ratio});
    write_reg(tps_pkg::REG_PMIN, {16'd0, pmin});
    write_reg(tps_pkg::REG_PMAX, {16'd0, pmax});
    write_reg(tps_pkg::REG_INIT_PERIOD, {16'd0, init_p});
    write_reg(tps_pkg::REG_OWN_ID, {24'd0, own});
  endtask

  always @(posedge clk) begin
    sched_result_t exp_res;
    if (!rst && done) begin
      if (exp_count == 0) begin
        report("result with no request outstanding");
      end else begin
        exp_res = expected_results[exp_head];
        exp_head = (exp_head + 1) % ExpDepth;
        exp_count--;
        if (send_now !== exp_res.send_now)
          report($sformatf("send_now %0b exp %0b", send_now, exp_res.send_now));
        if (next_send_time !== exp_res.next_send_time)
          report($sformatf("next_send_time %0d exp %0d", next_send_time,
                           exp_res.next_send_time));
        if (period_now !== exp_res.period_now)
          report($sformatf("period_now %0d exp %0d", period_now, exp_res.period_now));
        if (slot_index !== exp_res.slot_index)
          report($sformatf("slot_index %0d exp %0d", slot_index, exp_res.slot_index));
        if (peer_total !== exp_res.peer_total)
          report($sformatf("peer_total %0d exp %0d", peer_total, exp_res.peer_total));
        if (partner_online !== exp_res.partner_online)
          report($sformatf("partner_online %0b exp %0b", partner_online,
                           exp_res.partner_online));
        if (drop_flag !== exp_res.drop_flag)
          report($sformatf("drop_flag %0b exp %0b", drop_flag, exp_res.drop_flag));
      end
    end
  end

  // Two peers around own id in steady rhythm, then the extremes of the fields.
  task automatic test_directed();
    send_request(tps_pkg::REQ_SEND, 8'd0, 32'd0);
    send_request(tps_pkg::REQ_PACKET, 8'd2, 32'd10);
    send_request(tps_pkg::REQ_PACKET, 8'd0, 32'd40);
    send_request(tps_pkg::REQ_PACKET, 8'd2, 32'd110);
    send_request(tps_pkg::REQ_PACKET, 8'd0, 32'd140);
    send_request(tps_pkg::REQ_PACKET, 8'd0, 32'd230);
    send_request(tps_pkg::REQ_SEND, 8'd0, 32'd150);
    send_request(tps_pkg::REQ_SEND, 8'd255, 32'd400);
    send_request(tps_pkg::REQ_PACKET, 8'd1, 32'd410);
    send_request(tps_pkg::REQ_PACKET, 8'd255, 32'd420);
    send_request(tps_pkg::REQ_PACKET, 8'd255, 32'd520);
    // long silence removes every other entry, own entry too
    send_request(tps_pkg::REQ_PACKET, 8'd2, 32'd5000);
    send_request(tps_pkg::REQ_SEND, 8'd0, 32'hFFFF_FFFF);
    send_request(tps_pkg::REQ_PACKET, 8'd1, 32'hFFFF_FFF0);
    send_request(tps_pkg::REQ_PACKET, 8'd128, 32'h0000_0010);
    send_request(tps_pkg::REQ_SEND, 8'd0, 32'h8000_0000);
    drain();
  endtask

  task automatic test_table_full();
    configure(8'd100, 16'hFFFF, 16'd50, 16'd256, 16'd20, 16'd1000);
    for (int i = 0; i < 18; i++)
      send_request(tps_pkg::REQ_PACKET, 8'(i * 13 + 5), 32'(1000 + i));
    send_request(tps_pkg::REQ_PACKET, 8'd100, 32'd2000);
    drain();
  endtask

  // Well-formed traffic: time runs forward in random steps up to step_max,
  // peers come from a small pool; a little noise in time and id.
  task automatic test_random(input int count, input int pool_size, input int step_max);
    logic [7:0] pool [32];
    logic [7:0] id;
    logic [31:0] t;
    int r;
    for (int i = 0; i < pool_size; i++) pool[i] = 8'($urandom_range(0, 255));
    pool[0] = cfg_own_id;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, step_max);
      t = clock_ms;
      if (r < 3) t = $urandom;
      else if (r < 5) clock_ms = clock_ms + $urandom_range(0, 70000);
      id = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                        : pool[$urandom_range(0, pool_size - 1)];
      send_request($urandom_range(0, 99) < 40 ? tps_pkg::REQ_SEND : tps_pkg::REQ_PACKET,
                   id, t);
    end
    drain();
  endtask

  initial begin
    cfg_own_id = 8'd1;
    cfg_dead = 16'd1000;
    cfg_init_period = 16'd100;
    cfg_ratio = 16'd256;
    cfg_pmin = 16'd20;
    cfg_pmax = 16'd1000;
    table_clear();
    cur_period = 16'd100;
    due_time = '0;
    last_sender = '0;
    period_sum = '0;
    period_samples = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    clock_ms = 32'hFFFF_F000;
    test_random(80, 4, 60);
    configure(8'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd65535);
    test_random(60, 5, 3);
    configure(8'd255, 16'd65535, 16'd65535, 16'd65535, 16'd1, 16'd65535);
    test_random(60, 20, 300);
    configure(8'd77, 16'd400, 16'd120, 16'd300, 16'd90, 16'd150);
    test_random(90, 6, 120);
    configure(8'd200, 16'd2000, 16'd30, 16'd200, 16'd25, 16'd40);
    test_random(90, 3, 40);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/tps_pkg.sv
rtl/tdma_peer_slot_scheduler_core.sv
test/tdma_peer_slot_scheduler_core_test.sv
